// File: hw/rtl/kpc_pkg.sv
package kpc_pkg;

    // fixed field widths
    localparam int KEY_W       = 18;
    localparam int SHORT_W     = 12;
    localparam int LONG_W      = 14;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_INDEX_W = 1;

    // reset values of the threshold registers
    localparam logic [SHORT_W-1:0] SHORT_TICKS_RST = SHORT_W'(5);
    localparam logic [LONG_W-1:0]  LONG_TICKS_RST  = LONG_W'(100);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHORT_TICKS = 1'b0,
        REG_LONG_TICKS  = 1'b1
    } cfg_reg_t;

    // per-lane key state, one-hot
    typedef enum logic [4:0] {
        ST_UP         = 5'b00001,
        ST_PRESS      = 5'b00010,
        ST_EARLY_DOWN = 5'b00100,
        ST_DOWN       = 5'b01000,
        ST_RELAX      = 5'b10000
    } lane_state_t;

    // thresholds shared by all lanes
    typedef struct packed {
        logic [SHORT_W-1:0] short_ticks;
        logic [LONG_W-1:0]  long_ticks;
    } thresh_t;

    // what one lane reports after its update
    typedef struct packed {
        logic latched;
        logic press;
        logic hold;
    } lane_flags_t;

    // input transaction
    typedef struct packed {
        logic [KEY_W-1:0] pressed_keys;
    } key_item_t;

    // output transaction
    typedef struct packed {
        logic [KEY_W-1:0] latched_flags;
        logic [KEY_W-1:0] press_flags;
        logic [KEY_W-1:0] hold_flags;
    } flag_item_t;

endpackage

// File: hw/rtl/kpc_stream_if.sv
interface kpc_stream_if #(
    parameter type data_t = logic
);

    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: hw/rtl/kpc_lane.sv
module kpc_lane #(
    parameter int COUNT_BITS = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  level,
    input  kpc_pkg::thresh_t      thresh,
    output kpc_pkg::lane_flags_t  flags_next
);

    localparam int CMP_W = ((COUNT_BITS > kpc_pkg::LONG_W) ? COUNT_BITS : kpc_pkg::LONG_W) + 1;

    logic                    level_reg;
    logic                    level_next;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;
    kpc_pkg::lane_state_t    state_reg;
    kpc_pkg::lane_state_t    state_next;
    logic                    latched_reg;
    logic                    latched_next;

    logic [COUNT_BITS-1:0]   count_base;
    logic [COUNT_BITS-1:0]   count_inc;
    logic [CMP_W-1:0]        cnt_ext;
    logic [CMP_W-1:0]        short_ext;
    logic [CMP_W-1:0]        short1_ext;
    logic [CMP_W-1:0]        long_ext;

    // counter restart on a level change, saturating increment
    always_comb
    begin
        level_next = level;
        count_base = (level != level_reg) ? '0 : count_reg;
        count_inc  = (&count_base) ? count_base : count_base + 1'b1;
        cnt_ext    = CMP_W'(count_inc);
        short_ext  = CMP_W'(thresh.short_ticks);
        short1_ext = short_ext + 1'b1;
        long_ext   = CMP_W'(thresh.long_ticks);
    end

    // state advance toward up for a released key, toward down for a held key
    always_comb
    begin
        state_next = state_reg;
        count_next = '0;
        if (!level)
        begin
            if (state_reg != kpc_pkg::ST_UP)
            begin
                count_next = count_inc;
                priority if (cnt_ext >= short1_ext)
                    state_next = kpc_pkg::ST_UP;
                else if (cnt_ext >= short_ext)
                    state_next = kpc_pkg::ST_RELAX;
                else
                    state_next = state_reg;
            end
        end
        else
        begin
            if (state_reg != kpc_pkg::ST_DOWN)
            begin
                count_next = count_inc;
                priority if (cnt_ext >= long_ext)
                    state_next = kpc_pkg::ST_DOWN;
                else if (cnt_ext >= short1_ext)
                    state_next = kpc_pkg::ST_EARLY_DOWN;
                else if (cnt_ext >= short_ext)
                    state_next = kpc_pkg::ST_PRESS;
                else
                    state_next = state_reg;
            end
        end
    end

    // latched flag follows the updated state
    always_comb
    begin
        latched_next = latched_reg;
        if (state_next == kpc_pkg::ST_EARLY_DOWN)
            latched_next = 1'b1;
        else if (state_next == kpc_pkg::ST_RELAX)
            latched_next = 1'b0;
        flags_next.latched = latched_next;
        flags_next.press   = (state_next == kpc_pkg::ST_PRESS);
        flags_next.hold    = (state_next == kpc_pkg::ST_DOWN);
    end

    // lane registers, updated once per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= 1'b0;
            count_reg   <= '0;
            state_reg   <= kpc_pkg::ST_UP;
            latched_reg <= 1'b0;
        end
        else if (step)
        begin
            level_reg   <= level_next;
            count_reg   <= count_next;
            state_reg   <= state_next;
            latched_reg <= latched_next;
        end
    end

    // early down always carries the latch, relax never does
    a_early_down_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kpc_pkg::ST_EARLY_DOWN) |-> latched_reg)
        else $error("early down lane without latched flag");

    a_relax_unlatched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kpc_pkg::ST_RELAX) |-> !latched_reg)
        else $error("relax lane with latched flag");

    // at its target state the counter rests at zero; checked here for a key held in down
    a_target_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (step && level && state_reg == kpc_pkg::ST_DOWN) |=> (count_reg == '0))
        else $error("counter not cleared while held in down");

endmodule

// File: hw/rtl/kpc_merge.sv
module kpc_merge #(
    parameter int NUM_KEYS = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kpc_pkg::lane_flags_t  lane_flags [NUM_KEYS],
    kpc_stream_if.source          flag_out
);

    kpc_pkg::flag_item_t  merged;
    kpc_pkg::flag_item_t  out_data_reg;
    kpc_pkg::flag_item_t  skid_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic                 in_accept;
    logic                 out_free;

    // gather lane flags into the output fields
    for (genvar i = 0; i < kpc_pkg::KEY_W; i++)
    begin : g_pack
        if (i < NUM_KEYS)
        begin : g_lane
            assign merged.latched_flags[i] = lane_flags[i].latched;
            assign merged.press_flags[i]   = lane_flags[i].press;
            assign merged.hold_flags[i]    = lane_flags[i].hold;
        end
        else
        begin : g_none
            assign merged.latched_flags[i] = 1'b0;
            assign merged.press_flags[i]   = 1'b0;
            assign merged.hold_flags[i]    = 1'b0;
        end
    end

    // handshake: skid slot keeps ready off the output's ready path
    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || flag_out.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || in_accept;
            skid_valid_next = 1'b0;
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_accept)
                out_data_reg <= merged;
        end
        else if (in_accept)
        begin
            skid_data_reg <= merged;
        end
    end

    assign flag_out.valid = out_valid_reg;
    assign flag_out.data  = out_data_reg;

    // skid slot is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with empty output register");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && out_valid_reg && !flag_out.ready) |=> skid_valid_reg)
        else $error("transaction accepted under stall was not parked");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && flag_out.ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid slot did not move to the output register");

endmodule

// File: hw/rtl/key_press_classifier.sv
// the flags for an accepted key transaction are registered in the output stage
// throughput: one transaction per cycle while unstalled; lanes update in parallel
// a two-entry output stage (register plus skid slot) keeps input ready registered
// reset (rst_n, async, active low): lanes up with zero counters and clear latches,
// short_ticks = 5, long_ticks = 100, no pending output
module key_press_classifier #(
    parameter int NUM_KEYS   = 18,
    parameter int COUNT_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    kpc_stream_if.sink                           key_in,
    kpc_stream_if.source                         flag_out,
    input  logic                                 cfg_we,
    input  logic [kpc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [kpc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    kpc_pkg::thresh_t      thresh_reg;
    kpc_pkg::lane_flags_t  lane_flags [NUM_KEYS];
    logic                  step;

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.short_ticks <= kpc_pkg::SHORT_TICKS_RST;
            thresh_reg.long_ticks  <= kpc_pkg::LONG_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kpc_pkg::REG_SHORT_TICKS:
                    thresh_reg.short_ticks <= cfg_wdata[kpc_pkg::SHORT_W-1:0];
                kpc_pkg::REG_LONG_TICKS:
                    thresh_reg.long_ticks  <= cfg_wdata[kpc_pkg::LONG_W-1:0];
                default:
                    thresh_reg <= thresh_reg;
            endcase
        end
    end

    assign step = key_in.valid && key_in.ready;

    // key lanes
    for (genvar i = 0; i < NUM_KEYS; i++)
    begin : g_lane
        logic level;
        if (i < kpc_pkg::KEY_W)
        begin : g_in
            assign level = key_in.data.pressed_keys[i];
        end
        else
        begin : g_idle
            assign level = 1'b0;
        end

        kpc_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .step       (step),
            .level      (level),
            .thresh     (thresh_reg),
            .flags_next (lane_flags[i])
        );
    end

    // merge lane flags and hold the result
    kpc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (key_in.valid),
        .in_ready   (key_in.ready),
        .lane_flags (lane_flags),
        .flag_out   (flag_out)
    );

endmodule
